// File: hdl/pce_pkg.sv
`default_nettype none

package pce_pkg;

   localparam int DATA_W              = 32;
   localparam int REQ_W               = 2;
   localparam int IDX_OUT_W           = 10;
   localparam int COUNT_W             = 11;
   localparam int STAT_W              = 2;
   localparam int FRAC_W              = 16;
   // Q16.16 product width before rounding; wider ones saturate
   localparam int RAW_W               = 64;
   // Intermediates hold +-(2^60 - 1)
   localparam int WIDE_W              = 61;
   localparam int SUM_W               = 63;
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD,
      REQ_VALUE,
      REQ_SLOPE,
      REQ_IGNORE
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK,
      ST_FULL,
      ST_BEYOND,
      ST_SAT
   } status_code_type;

   // One multiplication and how its product is folded in
   typedef enum logic [2:0] {
      STEP_DS2,
      STEP_DS3,
      STEP_VB,
      STEP_VC,
      STEP_VD,
      STEP_DC,
      STEP_DD
   } step_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_FULL,
      RES_BEYOND,
      RES_LOADED,
      RES_EVAL
   } res_kind_type;

   typedef struct packed {
      logic [DATA_W-1:0] start;
      logic [DATA_W-1:0] coef_a;
      logic [DATA_W-1:0] coef_b;
      logic [DATA_W-1:0] coef_c;
      logic [DATA_W-1:0] coef_d;
   } seg_type;

   typedef struct packed {
      logic         latch_req;
      logic         store;
      logic         walk_start;
      logic         walk_run;
      logic         form_ds;
      logic         mul_start;
      step_type     step;
      logic         res_en;
      res_kind_type res_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      req_code_type req_code;
      logic         table_full;
      logic         group_empty;
      logic         group_beyond;
      logic         walk_end;
      logic         mul_done;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: hdl/pce_if.sv
`default_nettype none

interface pce_req_if import pce_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [DATA_W-1:0] seg_start;
   logic signed [DATA_W-1:0] coef_a;
   logic signed [DATA_W-1:0] coef_b;
   logic signed [DATA_W-1:0] coef_c;
   logic signed [DATA_W-1:0] coef_d;
   logic [IDX_OUT_W-1:0]     first_index;
   logic [COUNT_W-1:0]       seg_count;
   logic signed [DATA_W-1:0] s_coord;

   modport source (
      output valid, req_type, seg_start, coef_a, coef_b, coef_c, coef_d,
             first_index, seg_count, s_coord,
      input  ready
   );
   modport sink (
      input  valid, req_type, seg_start, coef_a, coef_b, coef_c, coef_d,
             first_index, seg_count, s_coord,
      output ready
   );
endinterface

interface pce_rsp_if import pce_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic [IDX_OUT_W-1:0]     stored_index;
   logic [STAT_W-1:0]        status;

   modport source (output valid, value, stored_index, status, input ready);
   modport sink   (input valid, value, stored_index, status, output ready);
endinterface

`default_nettype wire

// File: hdl/pce_mul.sv
`default_nettype none

// Sign-magnitude Q16.16 multiply on one shared 32x32 multiplier.
// Start latches operands; done marks the product valid.
module pce_mul import pce_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [WIDE_W-1:0] x,
   input  wire logic signed [DATA_W:0]   y,
   output logic                          done,
   output logic signed [WIDE_W-1:0]      product
);

   localparam int MAG_W  = WIDE_W - 1;
   localparam int HI_W   = MAG_W - DATA_W;
   localparam int PP_W   = 2 * DATA_W;
   localparam int PROD_W = MAG_W + DATA_W;

   logic [4:0]               v_ff;
   logic [MAG_W-1:0]         ux_ff;
   logic [DATA_W-1:0]        uy_ff;
   logic                     neg_ff;
   logic [PP_W-1:0]          lo_ff;
   logic [HI_W+DATA_W-1:0]   hi_ff;
   logic [PROD_W-1:0]        p_ff;
   logic signed [WIDE_W-1:0] product_ff;

   logic [MAG_W-1:0]         ux_in;
   logic [DATA_W-1:0]        uy_in;
   logic [DATA_W-1:0]        mul_a;
   logic [PP_W-1:0]          mul_out;
   logic                     sat;
   logic [RAW_W-1:0]         rounded;
   logic [MAG_W-1:0]         r_mag;
   logic [WIDE_W-1:0]        pos;
   logic signed [WIDE_W-1:0] product_in;

   always_comb begin
      ux_in   = x[WIDE_W-1] ? MAG_W'(-x) : MAG_W'(x);
      uy_in   = y[DATA_W] ? DATA_W'(-y) : DATA_W'(y);
      // low half first, then high half
      mul_a   = v_ff[0] ? ux_ff[DATA_W-1:0] : DATA_W'(ux_ff[MAG_W-1:DATA_W]);
      mul_out = PP_W'(mul_a) * PP_W'(uy_ff);
      // anything at or above 2^64 - 2^15 pins to the wide maximum
      sat     = (|p_ff[PROD_W-1:RAW_W]) || (&p_ff[RAW_W-1:FRAC_W-1]);
      rounded = p_ff[RAW_W-1:0] + (RAW_W'(1) << (FRAC_W - 1));
      r_mag   = sat ? {MAG_W{1'b1}} : MAG_W'(rounded[RAW_W-1:FRAC_W]);
      pos     = {1'b0, r_mag};
      product_in = neg_ff ? -$signed(pos) : $signed(pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[3:0], start};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ux_ff  <= ux_in;
         uy_ff  <= uy_in;
         neg_ff <= x[WIDE_W-1] ^ y[DATA_W];
      end
      if (v_ff[0]) begin
         lo_ff <= mul_out;
      end
      if (v_ff[1]) begin
         hi_ff <= mul_out[HI_W+DATA_W-1:0];
      end
      if (v_ff[2]) begin
         p_ff <= {hi_ff, {DATA_W{1'b0}}} + PROD_W'(lo_ff);
      end
      if (v_ff[3]) begin
         product_ff <= product_in;
      end
   end

   assign done    = v_ff[4];
   assign product = product_ff;

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##5 done)
      else $error("multiply result not on time");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      start |-> (v_ff == '0))
      else $error("multiply started while busy");

endmodule

`default_nettype wire

// File: hdl/pce_datapath.sv
`default_nettype none

module pce_datapath import pce_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [REQ_W-1:0]         req_type,
   input  wire logic signed [DATA_W-1:0] seg_start,
   input  wire logic signed [DATA_W-1:0] coef_a,
   input  wire logic signed [DATA_W-1:0] coef_b,
   input  wire logic signed [DATA_W-1:0] coef_c,
   input  wire logic signed [DATA_W-1:0] coef_d,
   input  wire logic [IDX_OUT_W-1:0]     first_index,
   input  wire logic [COUNT_W-1:0]       seg_count,
   input  wire logic signed [DATA_W-1:0] s_coord,
   input  wire ctrl_cmd_type             cmd,
   output dp_stat_type                   stat,
   output logic signed [DATA_W-1:0]      value,
   output logic [IDX_OUT_W-1:0]          stored_index,
   output logic [STAT_W-1:0]             status
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W  = (FILL_W > IDX_OUT_W + 2) ? FILL_W : IDX_OUT_W + 2;

   localparam logic signed [SUM_W-1:0]  SUM_HI  = {{(SUM_W-WIDE_W){1'b0}}, WIDE_MAX};
   localparam logic signed [SUM_W-1:0]  SUM_LO  = -SUM_HI;
   localparam logic signed [WIDE_W-1:0] EVAL_HI =
      {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] EVAL_LO =
      {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

   function automatic logic signed [WIDE_W-1:0] clamp_wide(input logic signed [SUM_W-1:0] v);
      logic signed [WIDE_W-1:0] r;
      if (v > SUM_HI) begin
         r = WIDE_MAX;
      end else if (v < SUM_LO) begin
         r = -WIDE_MAX;
      end else begin
         r = v[WIDE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SUM_W-1:0] ext_wide(input logic signed [WIDE_W-1:0] v);
      return {{(SUM_W-WIDE_W){v[WIDE_W-1]}}, v};
   endfunction

   function automatic logic signed [SUM_W-1:0] ext_coef(input logic [DATA_W-1:0] v);
      return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   seg_type                  mem [TABLE_DEPTH];

   req_code_type             req_code_ff;
   seg_type                  seg_ff;
   logic [IDX_OUT_W-1:0]     first_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic signed [DATA_W-1:0] s_ff;
   logic [FILL_W-1:0]        fill_ff;
   logic [IDX_OUT_W-1:0]     load_idx_ff;

   logic [CMP_W-1:0]         iss_addr_ff;
   logic [COUNT_W-1:0]       iss_left_ff;
   logic                     rd_valid_ff;
   logic                     rd_last_ff;
   logic                     walk_first_ff;
   seg_type                  rd_row_ff;
   seg_type                  sel_row_ff;

   logic signed [DATA_W:0]   ds_ff;
   logic signed [WIDE_W-1:0] ds2_ff;
   logic signed [WIDE_W-1:0] ds3_ff;
   logic signed [WIDE_W-1:0] acc_ff;

   logic signed [DATA_W-1:0] value_ff;
   logic [IDX_OUT_W-1:0]     stored_index_ff;
   status_code_type          status_ff;
   logic signed [DATA_W-1:0] value_in;
   logic [IDX_OUT_W-1:0]     stored_index_in;
   status_code_type          status_in;

   logic                     rd_en;
   logic                     qual;
   logic signed [WIDE_W-1:0] mul_x;
   logic signed [DATA_W:0]   mul_y;
   logic                     mul_done;
   logic signed [WIDE_W-1:0] mul_p;
   logic signed [WIDE_W-1:0] ds_wide;
   logic signed [SUM_W-1:0]  p_ext;
   logic signed [SUM_W-1:0]  p_twice;
   logic signed [WIDE_W-1:0] term;
   logic signed [WIDE_W-1:0] acc_in;

   assign rd_en = cmd.walk_run && (iss_left_ff != '0);
   assign qual  = s_ff >= $signed(rd_row_ff.start);

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[fill_ff[IDX_W-1:0]] <= seg_ff;
      end
      if (rd_en) begin
         rd_row_ff <= mem[iss_addr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.store) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end
         rd_valid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_code_ff <= req_code_type'(req_type);
         seg_ff      <= '{start: seg_start, coef_a: coef_a, coef_b: coef_b,
                          coef_c: coef_c, coef_d: coef_d};
         first_ff    <= first_index;
         count_ff    <= seg_count;
         s_ff        <= s_coord;
      end
      if (cmd.store) begin
         load_idx_ff <= IDX_OUT_W'(fill_ff);
      end
      if (cmd.walk_start) begin
         iss_addr_ff   <= CMP_W'(first_ff);
         iss_left_ff   <= count_ff;
         walk_first_ff <= 1'b1;
      end else if (cmd.walk_run) begin
         if (rd_en) begin
            iss_addr_ff <= iss_addr_ff + CMP_W'(1);
            iss_left_ff <= iss_left_ff - COUNT_W'(1);
            rd_last_ff  <= (iss_left_ff == COUNT_W'(1));
         end
         // keep the latest qualifying row; the first row stands in if none qualifies
         if (rd_valid_ff) begin
            walk_first_ff <= 1'b0;
            if (walk_first_ff || qual) begin
               sel_row_ff <= rd_row_ff;
            end
         end
      end
      if (cmd.form_ds) begin
         ds_ff <= {s_ff[DATA_W-1], s_ff} - {sel_row_ff.start[DATA_W-1], sel_row_ff.start};
      end
   end

   assign ds_wide = {{(WIDE_W-DATA_W-1){ds_ff[DATA_W]}}, ds_ff};

   always_comb begin
      case (cmd.step)
         STEP_DS2: begin
            mul_x = ds_wide;
            mul_y = ds_ff;
         end
         STEP_DS3: begin
            mul_x = ds2_ff;
            mul_y = ds_ff;
         end
         STEP_VB: begin
            mul_x = ds_wide;
            mul_y = {sel_row_ff.coef_b[DATA_W-1], sel_row_ff.coef_b};
         end
         STEP_VC: begin
            mul_x = ds2_ff;
            mul_y = {sel_row_ff.coef_c[DATA_W-1], sel_row_ff.coef_c};
         end
         STEP_VD: begin
            mul_x = ds3_ff;
            mul_y = {sel_row_ff.coef_d[DATA_W-1], sel_row_ff.coef_d};
         end
         STEP_DC: begin
            mul_x = ds_wide;
            mul_y = {sel_row_ff.coef_c[DATA_W-1], sel_row_ff.coef_c};
         end
         STEP_DD: begin
            mul_x = ds2_ff;
            mul_y = {sel_row_ff.coef_d[DATA_W-1], sel_row_ff.coef_d};
         end
         default: begin
            mul_x = ds_wide;
            mul_y = ds_ff;
         end
      endcase
   end

   pce_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .done    (mul_done),
      .product (mul_p)
   );

   always_comb begin
      p_ext   = ext_wide(mul_p);
      p_twice = {mul_p[WIDE_W-1], mul_p, 1'b0};
      term    = '0;
      case (cmd.step)
         STEP_VB: begin
            acc_in = clamp_wide(ext_coef(sel_row_ff.coef_a) + p_ext);
         end
         STEP_VC, STEP_VD: begin
            acc_in = clamp_wide(ext_wide(acc_ff) + p_ext);
         end
         STEP_DC: begin
            term   = clamp_wide(p_twice);
            acc_in = clamp_wide(ext_coef(sel_row_ff.coef_b) + ext_wide(term));
         end
         STEP_DD: begin
            term   = clamp_wide(p_ext + p_twice);
            acc_in = clamp_wide(ext_wide(acc_ff) + ext_wide(term));
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_done) begin
         case (cmd.step)
            STEP_DS2: ds2_ff <= mul_p;
            STEP_DS3: ds3_ff <= mul_p;
            default:  acc_ff <= acc_in;
         endcase
      end
   end

   always_comb begin
      value_in        = '0;
      stored_index_in = '0;
      status_in       = ST_OK;
      case (cmd.res_kind)
         RES_FULL:   status_in = ST_FULL;
         RES_BEYOND: status_in = ST_BEYOND;
         RES_LOADED: stored_index_in = load_idx_ff;
         RES_EVAL: begin
            if (acc_ff > EVAL_HI) begin
               value_in  = EVAL_HI[DATA_W-1:0];
               status_in = ST_SAT;
            end else if (acc_ff < EVAL_LO) begin
               value_in  = EVAL_LO[DATA_W-1:0];
               status_in = ST_SAT;
            end else begin
               value_in = acc_ff[DATA_W-1:0];
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_en) begin
         value_ff        <= value_in;
         stored_index_ff <= stored_index_in;
         status_ff       <= status_in;
      end
   end

   assign value        = value_ff;
   assign stored_index = stored_index_ff;
   assign status       = status_ff;

   assign stat.req_code     = req_code_ff;
   assign stat.table_full   = (fill_ff == FILL_W'(TABLE_DEPTH));
   assign stat.group_empty  = (count_ff == '0);
   assign stat.group_beyond = (CMP_W'(first_ff) + CMP_W'(count_ff)) > CMP_W'(fill_ff);
   assign stat.walk_end     = rd_valid_ff && (!qual || rd_last_ff);
   assign stat.mul_done     = mul_done;

   a_store_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> !stat.table_full)
      else $error("segment stored into a full table");

   a_read_loaded: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (iss_addr_ff < CMP_W'(fill_ff)))
      else $error("group walk read past loaded entries");

endmodule

`default_nettype wire

// File: hdl/pce_ctrl.sv
`default_nettype none

module pce_ctrl import pce_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dp_stat_type stat,
   output ctrl_cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_LOAD,
      S_WALK,
      S_DIFF,
      S_MUL_GO,
      S_MUL_WAIT,
      S_FINISH
   } state_type;

   state_type    state_ff, state_in;
   step_type     step_ff, step_in;
   res_kind_type res_kind_ff, res_kind_in;
   logic         rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      res_kind_in  = res_kind_ff;
      cmd          = '0;
      cmd.step     = step_ff;
      cmd.res_kind = res_kind_ff;
      req_ready    = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            case (stat.req_code)
               REQ_LOAD: begin
                  if (stat.table_full) begin
                     res_kind_in = RES_FULL;
                  end else begin
                     state_in = S_LOAD;
                  end
               end
               REQ_VALUE, REQ_SLOPE: begin
                  if (stat.group_empty) begin
                     res_kind_in = RES_ZERO;
                  end else if (stat.group_beyond) begin
                     res_kind_in = RES_BEYOND;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               default: res_kind_in = RES_ZERO;
            endcase
         end
         S_LOAD: begin
            cmd.store   = 1'b1;
            res_kind_in = RES_LOADED;
            state_in    = S_FINISH;
         end
         S_WALK: begin
            cmd.walk_run = 1'b1;
            if (stat.walk_end) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.form_ds = 1'b1;
            step_in     = STEP_DS2;
            res_kind_in = RES_EVAL;
            state_in    = S_MUL_GO;
         end
         S_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (stat.mul_done) begin
               state_in = S_MUL_GO;
               case (step_ff)
                  STEP_DS2: step_in = (stat.req_code == REQ_VALUE) ? STEP_DS3 : STEP_DC;
                  STEP_DS3: step_in = STEP_VB;
                  STEP_VB:  step_in = STEP_VC;
                  STEP_VC:  step_in = STEP_VD;
                  STEP_DC:  step_in = STEP_DD;
                  default:  state_in = S_FINISH;
               endcase
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_en = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.res_en) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_DS2;
         res_kind_ff  <= RES_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         res_kind_ff  <= res_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result raised outside finish");

endmodule

`default_nettype wire

// File: hdl/piecewise_cubic_evaluator.sv
// Piecewise cubic evaluator: keeps a table of TABLE_DEPTH cubic segments (start and
// coefficients a..d, signed Q16.16) in one on-chip memory, appends a segment per load
// and evaluates p(ds) or p'(ds) for a group of segments, one transaction at a time.
// A load goes from decode through a store state to finish; refused loads, empty
// or out-of-range groups and the unused request code go from decode to finish.
// An evaluation scans the group one memory read a cycle until the first start above
// the coordinate or the group's end, then runs its multiplications one at a time
// through a single shared 32x32 multiplier. A result waits in the output register
// while rsp_ch.ready is low. The table has no reset sweep; entries become readable
// as they are loaded.
`default_nettype none

module piecewise_cubic_evaluator import pce_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   pce_req_if.sink   req_ch,
   pce_rsp_if.source rsp_ch
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   pce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pce_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_type     (req_ch.req_type),
      .seg_start    (req_ch.seg_start),
      .coef_a       (req_ch.coef_a),
      .coef_b       (req_ch.coef_b),
      .coef_c       (req_ch.coef_c),
      .coef_d       (req_ch.coef_d),
      .first_index  (req_ch.first_index),
      .seg_count    (req_ch.seg_count),
      .s_coord      (req_ch.s_coord),
      .cmd          (cmd),
      .stat         (stat),
      .value        (rsp_ch.value),
      .stored_index (rsp_ch.stored_index),
      .status       (rsp_ch.status)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import pce_pkg::*;

   localparam int     TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
   localparam int     RANDOM_ITEMS = 1752;
   localparam int     PHASES       = 8;
   localparam longint WIDE_LIMIT   = 64'sh0FFF_FFFF_FFFF_FFFF;
   localparam longint Q_MAX        = 64'sd2147483647;
   localparam longint Q_MIN        = -64'sd2147483648;

   typedef struct packed {
      logic [DATA_W-1:0]    value;
      logic [IDX_OUT_W-1:0] stored_index;
      status_code_type      status;
   } answer_type;

   typedef struct {
      req_code_type         kind;
      logic [DATA_W-1:0]    start;
      logic [DATA_W-1:0]    ca;
      logic [DATA_W-1:0]    cb;
      logic [DATA_W-1:0]    cc;
      logic [DATA_W-1:0]    cd;
      logic [IDX_OUT_W-1:0] first;
      logic [COUNT_W-1:0]   count;
      logic [DATA_W-1:0]    coord;
      bit                   typed;
      answer_type           answer;
   } stim_row_type;

   logic clock;
   logic reset;

   pce_req_if req_ch();
   pce_rsp_if rsp_ch();

   piecewise_cubic_evaluator #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   seg_type           shadow_segs [TABLE_DEPTH];
   int                loaded_count;
   logic [DATA_W-1:0] breakpoint_ramp;
   answer_type        answers_due [$];
   stim_row_type      directed_rows [$];
   int                send_gap_pct;
   int                recv_stall_pct;
   int                mismatch_count;
   int                kind_tally [4];
   int                status_tally [4];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("piecewise_cubic_evaluator regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint q_of(logic [DATA_W-1:0] x);
      return longint'($signed(x));
   endfunction

   function automatic longint clamp_q44(longint v);
      if (v > WIDE_LIMIT) return WIDE_LIMIT;
      if (v < -WIDE_LIMIT) return -WIDE_LIMIT;
      return v;
   endfunction

   // Q16.16 product: round magnitude half up, saturate when the exact product
   // reaches 2^64 - 2^15
   function automatic longint q16_mul(longint x, longint y);
      logic [127:0] mag;
      logic [63:0]  ux;
      logic [63:0]  uy;
      longint       r;
      ux = (x < 0) ? 64'(-x) : 64'(x);
      uy = (y < 0) ? 64'(-y) : 64'(y);
      mag = {64'd0, ux} * {64'd0, uy};
      if (mag > 128'h0000_0000_0000_0000_FFFF_FFFF_FFFF_7FFF) begin
         r = WIDE_LIMIT;
      end else begin
         mag = (mag + 128'h8000) >> FRAC_W;
         r = (mag > WIDE_LIMIT) ? WIDE_LIMIT : longint'(mag[63:0]);
      end
      return ((x < 0) != (y < 0)) ? -r : r;
   endfunction

   function automatic answer_type predict_answer(stim_row_type r);
      answer_type ans;
      int         act;
      longint     s, ds, ds2, ds3, a, b, c, d, sum;
      ans = '0;
      ans.status = ST_OK;
      case (r.kind)
         REQ_LOAD: begin
            if (loaded_count >= TABLE_DEPTH) begin
               ans.status = ST_FULL;
            end else begin
               shadow_segs[loaded_count] = '{r.start, r.ca, r.cb, r.cc, r.cd};
               ans.stored_index = IDX_OUT_W'(loaded_count);
               loaded_count++;
            end
         end
         REQ_IGNORE: ;
         default: begin
            if (r.count == 0) return ans;
            if (int'(r.first) + int'(r.count) > loaded_count) begin
               ans.status = ST_BEYOND;
               return ans;
            end
            s = q_of(r.coord);
            act = int'(r.first);
            // keep the last start not above the coordinate, stop at the first above
            for (int i = 0; i < int'(r.count); i++) begin
               if (s >= q_of(shadow_segs[int'(r.first) + i].start))
                  act = int'(r.first) + i;
               else
                  break;
            end
            ds = s - q_of(shadow_segs[act].start);
            a = q_of(shadow_segs[act].coef_a);
            b = q_of(shadow_segs[act].coef_b);
            c = q_of(shadow_segs[act].coef_c);
            d = q_of(shadow_segs[act].coef_d);
            ds2 = q16_mul(ds, ds);
            if (r.kind == REQ_VALUE) begin
               ds3 = q16_mul(ds2, ds);
               sum = clamp_q44(a + q16_mul(b, ds));
               sum = clamp_q44(sum + q16_mul(c, ds2));
               sum = clamp_q44(sum + q16_mul(d, ds3));
            end else begin
               sum = clamp_q44(b + clamp_q44(2 * q16_mul(c, ds)));
               sum = clamp_q44(sum + clamp_q44(3 * q16_mul(d, ds2)));
            end
            if (sum > Q_MAX) begin
               ans.value = 32'h7FFF_FFFF;
               ans.status = ST_SAT;
            end else if (sum < Q_MIN) begin
               ans.value = 32'h8000_0000;
               ans.status = ST_SAT;
            end else begin
               ans.value = sum[DATA_W-1:0];
            end
         end
      endcase
      return ans;
   endfunction

   // ------------------------------------------------------------ stimulus rows

   function automatic stim_row_type seg(logic [DATA_W-1:0] start, logic [DATA_W-1:0] ca,
                                        logic [DATA_W-1:0] cb, logic [DATA_W-1:0] cc,
                                        logic [DATA_W-1:0] cd);
      stim_row_type r;
      r.kind = REQ_LOAD;
      r.start = start;
      r.ca = ca;
      r.cb = cb;
      r.cc = cc;
      r.cd = cd;
      r.first = '0;
      r.count = '0;
      r.coord = '0;
      r.typed = 1'b0;
      r.answer = '0;
      return r;
   endfunction

   function automatic stim_row_type ask(req_code_type kind, logic [IDX_OUT_W-1:0] first,
                                        logic [COUNT_W-1:0] count, logic [DATA_W-1:0] coord);
      stim_row_type r;
      r = seg('0, '0, '0, '0, '0);
      r.kind = kind;
      r.first = first;
      r.count = count;
      r.coord = coord;
      return r;
   endfunction

   function automatic stim_row_type known(stim_row_type r, logic [DATA_W-1:0] value,
                                          logic [IDX_OUT_W-1:0] idx, status_code_type st);
      r.typed = 1'b1;
      r.answer.value = value;
      r.answer.stored_index = idx;
      r.answer.status = st;
      return r;
   endfunction

   function automatic void add_row(stim_row_type r);
      directed_rows = {directed_rows, r};
   endfunction

   function automatic logic [DATA_W-1:0] pick_coef();
      int v;
      if ($urandom_range(3) == 0) return $urandom();
      // mostly within +-4.0 so that the cubic does not always saturate
      v = int'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      return v;
   endfunction

   function automatic stim_row_type random_row(int remaining);
      stim_row_type r;
      int           pick, need, longest, cnt, fst, m;
      bit           full, must_load;
      r = ask(REQ_VALUE, IDX_OUT_W'($urandom()), COUNT_W'($urandom_range(TABLE_DEPTH)),
              $urandom());
      r.start = $urandom();
      r.ca = $urandom();
      r.cb = $urandom();
      r.cc = $urandom();
      r.cd = $urandom();
      pick = $urandom_range(99);
      full = loaded_count >= TABLE_DEPTH;
      must_load = !full && (remaining <= TABLE_DEPTH - loaded_count + 40);
      if (must_load || (!full && pick < 65) || (full && pick < 12)) begin
         r.kind = REQ_LOAD;
         // ascending breakpoints, with a fresh ramp now and then
         if ($urandom_range(9) == 0)
            breakpoint_ramp = $urandom();
         else
            breakpoint_ramp = breakpoint_ramp + $urandom_range(32'h0003_0000, 32'h100);
         if ($urandom_range(19) != 0) r.start = breakpoint_ramp;
         r.ca = pick_coef();
         r.cb = pick_coef();
         r.cc = pick_coef();
         r.cd = pick_coef();
      end else if (pick >= 90 || loaded_count == 0) begin
         // empty group, group past the loaded entries, unused code
         r.kind = $urandom_range(1) ? REQ_SLOPE : REQ_VALUE;
         case ($urandom_range(2))
            0: r.count = '0;
            1: begin
               fst = $urandom_range(TABLE_DEPTH - 1);
               need = loaded_count + 1 - fst;
               if (need > TABLE_DEPTH) begin
                  fst = TABLE_DEPTH - 1;
                  need = loaded_count + 1 - fst;
               end
               if (need < 1) need = 1;
               r.first = IDX_OUT_W'(fst);
               r.count = COUNT_W'($urandom_range(TABLE_DEPTH, need));
            end
            default: r.kind = REQ_IGNORE;
         endcase
      end else begin
         r.kind = $urandom_range(1) ? REQ_SLOPE : REQ_VALUE;
         if ($urandom_range(39) == 0) begin
            cnt = (full && $urandom_range(4) == 0) ? TABLE_DEPTH
                                                   : $urandom_range(loaded_count, 1);
         end else begin
            longest = (loaded_count < 8) ? loaded_count : 8;
            cnt = $urandom_range(longest, 1);
         end
         fst = $urandom_range(loaded_count - cnt);
         m = fst + $urandom_range(cnt - 1);
         r.first = IDX_OUT_W'(fst);
         r.count = COUNT_W'(cnt);
         if ($urandom_range(6) != 0)
            r.coord = shadow_segs[m].start + $urandom_range(32'h0004_0000) - 32'h0002_0000;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------ driving

   task automatic issue(stim_row_type r);
      answer_type ans;
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= r.kind;
      req_ch.seg_start   <= r.start;
      req_ch.coef_a      <= r.ca;
      req_ch.coef_b      <= r.cb;
      req_ch.coef_c      <= r.cc;
      req_ch.coef_d      <= r.cd;
      req_ch.first_index <= r.first;
      req_ch.seg_count   <= r.count;
      req_ch.s_coord     <= r.coord;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ans = predict_answer(r);
      if (r.typed) ans = r.answer;
      answers_due = {answers_due, ans};
      kind_tally[int'(r.kind)]++;
      status_tally[int'(ans.status)]++;
   endtask

   task automatic compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // Result side: check each transaction, then pick the next ready
   initial begin
      answer_type want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (answers_due.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected result, expected none, got value %h index %0d status %0d",
                        $time, rsp_ch.value, rsp_ch.stored_index, rsp_ch.status);
            end else begin
               want = answers_due.pop_front();
               compare_field("value", want.value, rsp_ch.value);
               compare_field("stored_index", 32'(want.stored_index), 32'(rsp_ch.stored_index));
               compare_field("status", 32'(want.status), 32'(rsp_ch.status));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int issued;
      int per_phase;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = '0;
      req_ch.seg_start   = '0;
      req_ch.coef_a      = '0;
      req_ch.coef_b      = '0;
      req_ch.coef_c      = '0;
      req_ch.coef_d      = '0;
      req_ch.first_index = '0;
      req_ch.seg_count   = '0;
      req_ch.s_coord     = '0;
      send_gap_pct       = 0;
      recv_stall_pct     = 0;
      mismatch_count     = 0;
      loaded_count       = 0;
      breakpoint_ramp    = '0;
      issued             = 0;
      per_phase          = RANDOM_ITEMS / PHASES;
      foreach (kind_tally[i]) kind_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;

      add_row(known(ask(REQ_VALUE, 0, 0, 32'h0001_0000), 0, 0, ST_OK));
      add_row(known(ask(REQ_SLOPE, 0, 1, 0), 0, 0, ST_BEYOND));
      add_row(known(ask(REQ_IGNORE, 10'h3FF, 11'h400, '1), 0, 0, ST_OK));
      add_row(known(seg(0, 32'h0001_0000, 0, 0, 0), 0, 0, ST_OK));
      add_row(known(seg(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000,
                        32'h0000_8000, 32'hFFFF_C000), 0, 1, ST_OK));
      add_row(known(seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, 2, ST_OK));
      add_row(known(seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000), 0, 3, ST_OK));
      add_row(known(seg(32'h0002_0000, 32'h0000_4000, 32'hFFFE_8000,
                        32'h0001_0000, 32'h0000_2000), 0, 4, ST_OK));
      add_row(ask(REQ_VALUE, 0, 2, 32'h0001_8000));
      add_row(ask(REQ_SLOPE, 0, 2, 32'h0001_8000));
      add_row(known(ask(REQ_VALUE, 0, 1, 0), 32'h0001_0000, 0, ST_OK));
      // coordinate below the first start falls back to the first segment
      add_row(ask(REQ_VALUE, 1, 1, 32'hFFFB_0000));
      add_row(ask(REQ_VALUE, 2, 1, 32'h8000_0000));
      add_row(ask(REQ_VALUE, 3, 1, 32'h7FFF_FFFF));
      add_row(ask(REQ_SLOPE, 2, 1, 32'h8000_0000));
      add_row(ask(REQ_SLOPE, 3, 1, 32'h7FFF_FFFF));
      add_row(ask(REQ_VALUE, 1, 4, 32'h0003_0000));
      add_row(ask(REQ_SLOPE, 3, 2, 32'h0005_0000));
      add_row(known(ask(REQ_VALUE, 4, 2, 0), 0, 0, ST_BEYOND));
      add_row(known(ask(REQ_SLOPE, 10'h3FF, 11'h400, 32'h7FFF_FFFF), 0, 0, ST_BEYOND));
      add_row(known(ask(REQ_SLOPE, 10'h3FF, 0, 0), 0, 0, ST_OK));
      add_row(ask(REQ_VALUE, 0, 5, 0));
      add_row(ask(REQ_SLOPE, 0, 5, 32'h0002_0000));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) issue(directed_rows[i]);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 59; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 59; end
            default: begin send_gap_pct = 20; recv_stall_pct = 20; end
         endcase
         for (int k = 0; k < per_phase; k++) begin
            issue(random_row(RANDOM_ITEMS - issued));
            issued++;
         end
      end
      req_ch.valid <= 1'b0;

      // drain, then hold a while to catch stray results
      while (answers_due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("covered %0d transactions: %0d loads, %0d value, %0d slope, %0d unused-code",
               kind_tally.sum(), kind_tally[REQ_LOAD], kind_tally[REQ_VALUE],
               kind_tally[REQ_SLOPE], kind_tally[REQ_IGNORE]);
      $display("statuses ok %0d, full %0d, beyond %0d, saturated %0d; table at %0d of %0d",
               status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_BEYOND],
               status_tally[ST_SAT], loaded_count, TABLE_DEPTH);
      if (mismatch_count == 0)
         $display("piecewise_cubic_evaluator regression: pass");
      else
         $display("piecewise_cubic_evaluator regression: fail");
      $finish;
   end

endmodule
